// ===== sv/rauc_pkg.sv =====
// Package for the raw audio unit converter: unit codes, status codes,
// widths and the record that travels down the divider chain. No dependencies.
package rauc_pkg;

    localparam int AMT_W  = 64;
    localparam int SCL_W  = 32;                 // numerator and denominator width
    localparam int QUO_W  = AMT_W - 1;          // quotient bits below saturation
    localparam int PROD_W = AMT_W + SCL_W;
    localparam int TIME_UNITS_PER_SECOND_DEF = 1000000000;

    localparam logic [1:0] UNIT_FRAMES = 2'd0;
    localparam logic [1:0] UNIT_BYTES  = 2'd1;
    localparam logic [1:0] UNIT_NS     = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_META     = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

    localparam logic [0:0] REG_BYTES_PER_FRAME = 1'b0;
    localparam logic [0:0] REG_SAMPLE_RATE     = 1'b1;

    localparam logic [AMT_W-1:0] MAX_POS = {1'b0, {(AMT_W-1){1'b1}}};

    // result fixed before the divide, or saturated
    typedef struct packed {
        logic             direct;
        logic [AMT_W-1:0] amount;
        logic [1:0]       status;
        logic             ovf;
    } side_t;

    typedef struct packed {
        logic             valid;
        logic [SCL_W-1:0] rem;
        logic [QUO_W-1:0] work;   // dividend bits out, quotient bits in
        logic [SCL_W-1:0] den;
        side_t            side;
    } cell_t;

endpackage

// ===== sv/rauc_front.sv =====
// Front end: decodes the unit pair, forms numerator and denominator, splits
// the 64x32 multiply over two stages and seeds the divider chain. Uses rauc_pkg.
module rauc_front #(
    parameter int TIME_UNITS_PER_SECOND = rauc_pkg::TIME_UNITS_PER_SECOND_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [1:0]               source_unit,
    input  logic [1:0]               target_unit,
    input  logic [rauc_pkg::AMT_W-1:0] source_amount,
    input  logic [10:0]              bytes_per_frame,
    input  logic [19:0]              sample_rate,
    output rauc_pkg::cell_t          cell_out
);
    import rauc_pkg::*;

    localparam logic [SCL_W-1:0] TUNITS = SCL_W'(TIME_UNITS_PER_SECOND);

    logic             a_valid_reg;
    logic [AMT_W-1:0] a_amt_reg;
    logic [SCL_W-1:0] a_num_reg, a_den_reg;
    side_t            a_side_reg;
    logic [SCL_W-1:0] a_num_next, a_den_next;
    side_t            a_side_next;
    logic [SCL_W-1:0] br;

    logic                   b_valid_reg;
    logic [2*SCL_W-1:0]     b_lo_reg, b_hi_reg;
    logic [SCL_W-1:0]       b_den_reg;
    side_t                  b_side_reg;

    cell_t            c_reg;
    cell_t            c_next;
    logic [PROD_W-1:0] prod;
    logic [SCL_W:0]   top_bits;

    assign br = SCL_W'(bytes_per_frame) * SCL_W'(sample_rate);

    always_comb begin
        a_num_next = '0;
        a_den_next = '0;
        a_side_next = '{direct: 1'b1, amount: '0, status: ST_OK, ovf: 1'b0};
        if (source_unit == target_unit || source_amount == '0 || source_amount == '1) begin
            a_side_next.amount = source_amount;
        end else if (bytes_per_frame == '0 || sample_rate == '0) begin
            a_side_next.status = ST_NO_META;
        end else begin
            a_side_next.direct = 1'b0;
            if (source_unit == UNIT_BYTES && target_unit == UNIT_FRAMES) begin
                a_num_next = SCL_W'(1);
                a_den_next = SCL_W'(bytes_per_frame);
            end else if (source_unit == UNIT_BYTES && target_unit == UNIT_NS) begin
                a_num_next = TUNITS;
                a_den_next = br;
            end else if (source_unit == UNIT_FRAMES && target_unit == UNIT_BYTES) begin
                a_num_next = SCL_W'(bytes_per_frame);
                a_den_next = SCL_W'(1);
            end else if (source_unit == UNIT_FRAMES && target_unit == UNIT_NS) begin
                a_num_next = TUNITS;
                a_den_next = SCL_W'(sample_rate);
            end else if (source_unit == UNIT_NS && target_unit == UNIT_BYTES) begin
                a_num_next = br;
                a_den_next = TUNITS;
            end else if (source_unit == UNIT_NS && target_unit == UNIT_FRAMES) begin
                a_num_next = SCL_W'(sample_rate);
                a_den_next = TUNITS;
            end else begin
                a_side_next.direct = 1'b1;
                a_side_next.status = ST_UNSUPPORTED;
            end
        end
    end

    // combine partial products; saturate when the quotient reaches 2^63
    always_comb begin
        prod = {b_hi_reg, {SCL_W{1'b0}}} + PROD_W'(b_lo_reg);
        top_bits = prod[PROD_W-1:QUO_W];
        c_next.valid = b_valid_reg;
        c_next.den   = b_den_reg;
        c_next.side  = b_side_reg;
        c_next.rem   = top_bits[SCL_W-1:0];
        c_next.work  = prod[QUO_W-1:0];
        if (!b_side_reg.direct && top_bits >= {1'b0, b_den_reg}) begin
            c_next.side.direct = 1'b1;
            c_next.side.amount = MAX_POS;
            c_next.side.ovf    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_reg.valid <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_reg.valid <= c_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_amt_reg  <= source_amount;
            a_num_reg  <= a_num_next;
            a_den_reg  <= a_den_next;
            a_side_reg <= a_side_next;
            b_lo_reg   <= a_amt_reg[SCL_W-1:0] * a_num_reg;
            b_hi_reg   <= a_amt_reg[AMT_W-1:SCL_W] * a_num_reg;
            b_den_reg  <= a_den_reg;
            b_side_reg <= a_side_reg;
            c_reg.rem  <= c_next.rem;
            c_reg.work <= c_next.work;
            c_reg.den  <= c_next.den;
            c_reg.side <= c_next.side;
        end
    end

    assign cell_out = c_reg;

endmodule

// ===== sv/rauc_div_cell.sv =====
// One restoring-division cell: produces one quotient bit and passes the
// record to its neighbor. Uses rauc_pkg.
module rauc_div_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  rauc_pkg::cell_t cell_in,
    output rauc_pkg::cell_t cell_out
);
    import rauc_pkg::*;

    cell_t          c_reg;
    cell_t          c_next;
    logic [SCL_W:0] cur;
    logic           ge;

    always_comb begin
        cur = {cell_in.rem, cell_in.work[QUO_W-1]};
        ge  = cur >= {1'b0, cell_in.den};
        c_next      = cell_in;
        c_next.rem  = ge ? SCL_W'(cur - {1'b0, cell_in.den}) : cur[SCL_W-1:0];
        c_next.work = {cell_in.work[QUO_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg.valid <= 1'b0;
        end else if (en) begin
            c_reg.valid <= c_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg.rem  <= c_next.rem;
            c_reg.work <= c_next.work;
            c_reg.den  <= c_next.den;
            c_reg.side <= c_next.side;
        end
    end

    assign cell_out = c_reg;

endmodule

// ===== sv/raw_audio_unit_convert_top.sv =====
// Path from input transfer to result: 3 front stages, then 63 divider cells.
// Throughput: one item per cycle; the whole chain advances when the result
// register is empty or taken, so a stalled output holds every stage.
// Reset (aresetn low, synchronous): stage valid bits and both config
// registers clear; payload registers are not reset.
// Top level of the raw audio unit converter; uses rauc_pkg, rauc_front, rauc_div_cell.
module raw_audio_unit_convert_top #(
    parameter int TIME_UNITS_PER_SECOND = rauc_pkg::TIME_UNITS_PER_SECOND_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [31:0]                cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_source_unit,
    input  logic [1:0]                 s_target_unit,
    input  logic [rauc_pkg::AMT_W-1:0] s_source_amount,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [rauc_pkg::AMT_W-1:0] m_target_amount,
    output logic [1:0]                 m_status,
    output logic                       m_overflowed
);
    import rauc_pkg::*;

    logic [10:0] bpf_reg;
    logic [19:0] rate_reg;
    logic        en;
    cell_t       chain [0:QUO_W];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpf_reg  <= '0;
            rate_reg <= '0;
        end else if (cfg_valid && cfg_index[1] == 1'b0) begin
            if (cfg_index[0] == REG_BYTES_PER_FRAME) begin
                bpf_reg <= cfg_data[10:0];
            end else begin
                rate_reg <= cfg_data[19:0];
            end
        end
    end

    // advance the chain unless a finished result is held
    assign en      = !chain[QUO_W].valid || m_ready;
    assign s_ready = en;

    rauc_front #(
        .TIME_UNITS_PER_SECOND(TIME_UNITS_PER_SECOND)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .in_valid       (s_valid),
        .source_unit    (s_source_unit),
        .target_unit    (s_target_unit),
        .source_amount  (s_source_amount),
        .bytes_per_frame(bpf_reg),
        .sample_rate    (rate_reg),
        .cell_out       (chain[0])
    );

    genvar gi;
    generate
        for (gi = 0; gi < QUO_W; gi++) begin : g_cell
            rauc_div_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .cell_in (chain[gi]),
                .cell_out(chain[gi+1])
            );
        end
    endgenerate

    assign m_valid         = chain[QUO_W].valid;
    assign m_target_amount = chain[QUO_W].side.direct ? chain[QUO_W].side.amount
                                                      : {1'b0, chain[QUO_W].work};
    assign m_status        = chain[QUO_W].side.status;
    assign m_overflowed    = chain[QUO_W].side.ovf;

    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflowed |-> m_target_amount == MAX_POS && m_status == ST_OK)
        else $error("overflow flag without saturated amount");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_target_amount == '0 && !m_overflowed)
        else $error("error status with nonzero result");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && !s_ready || m_ready)
        else $error("held result lost or input taken during stall");

endmodule

// ===== tb/raw_audio_unit_convert_top_test.sv =====
// Self-checking bench for raw_audio_unit_convert_top: directed table, then random
// conversions under several register settings with random stalls on both sides.
// Depends on rauc_pkg and the converter RTL.
`timescale 1ns / 1ps

module raw_audio_unit_convert_top_test;
    import rauc_pkg::*;

    localparam logic [63:0] NONE_AMT = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [1:0]  UNIT_OTHER = 2'd3;
    localparam int          PHASE_ITEMS = 205;

    typedef struct {
        logic [63:0] amount;
        logic [1:0]  status;
        logic        ovf;
    } conv_res_t;

    typedef struct {
        logic [1:0]  src;
        logic [1:0]  dst;
        logic [63:0] amt;
        int          setting;   // index into the setting list
        bit          typed;     // expected result typed in below
        conv_res_t   res;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_source_unit;
    logic [1:0]  s_target_unit;
    logic [63:0] s_source_amount;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_target_amount;
    logic [1:0]  m_status;
    logic        m_overflowed;

    logic [10:0] bytes_per_frame;
    logic [19:0] sample_rate;
    conv_res_t   pending_q[$];
    dir_row_t    dir_rows[$];
    int          fail_count;
    int          results_seen;
    bit          hold_done;

    raw_audio_unit_convert_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_source_unit   (s_source_unit),
        .s_target_unit   (s_target_unit),
        .s_source_amount (s_source_amount),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_target_amount (m_target_amount),
        .m_status        (m_status),
        .m_overflowed    (m_overflowed)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // floor(v * num / den) with the product kept exact, saturated at 2^63-1
    function automatic conv_res_t convert_amount(logic [1:0] src, logic [1:0] dst,
                                                 logic [63:0] amt);
        conv_res_t    r;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        bit           scaled;
        r = '{amount: 64'd0, status: ST_OK, ovf: 1'b0};
        num = 128'd0;
        den = 128'd1;
        scaled = 1'b1;
        if (src == dst || amt == 64'd0 || amt == NONE_AMT) begin
            r.amount = amt;
            return r;
        end
        if (bytes_per_frame == 0 || sample_rate == 0) begin
            r.status = ST_NO_META;
            return r;
        end
        if (src == UNIT_BYTES && dst == UNIT_FRAMES) begin
            num = 1; den = bytes_per_frame;
        end else if (src == UNIT_BYTES && dst == UNIT_NS) begin
            num = TIME_UNITS_PER_SECOND_DEF; den = bytes_per_frame * sample_rate;
        end else if (src == UNIT_FRAMES && dst == UNIT_BYTES) begin
            num = bytes_per_frame; den = 1;
        end else if (src == UNIT_FRAMES && dst == UNIT_NS) begin
            num = TIME_UNITS_PER_SECOND_DEF; den = sample_rate;
        end else if (src == UNIT_NS && dst == UNIT_BYTES) begin
            num = bytes_per_frame * sample_rate; den = TIME_UNITS_PER_SECOND_DEF;
        end else if (src == UNIT_NS && dst == UNIT_FRAMES) begin
            num = sample_rate; den = TIME_UNITS_PER_SECOND_DEF;
        end else begin
            scaled = 1'b0;
        end
        if (!scaled) begin
            r.status = ST_UNSUPPORTED;
            return r;
        end
        quo = ({64'd0, amt} * num) / den;
        if (quo > {64'd0, MAX_POS}) begin
            r.amount = MAX_POS;
            r.ovf = 1'b1;
        end else begin
            r.amount = quo[63:0];
        end
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 45) return 0;
        if (p < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // drive one register write; the caller drops cfg_valid after the last one
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == {1'b0, REG_BYTES_PER_FRAME}) bytes_per_frame = data[10:0];
        else if (idx == {1'b0, REG_SAMPLE_RATE}) sample_rate = data[19:0];
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
    endtask

    task automatic apply_setting(int b, int r);
        drain_results();
        write_reg({1'b0, REG_BYTES_PER_FRAME}, b);
        write_reg({1'b0, REG_SAMPLE_RATE}, r);
        cfg_valid <= 1'b0;
    endtask

    // one transfer; hold valid across a zero gap so the next item follows back to back
    task automatic send_query(logic [1:0] src, logic [1:0] dst, logic [63:0] amt,
                              bit typed, conv_res_t res);
        int g;
        s_valid         <= 1'b1;
        s_source_unit   <= src;
        s_target_unit   <= dst;
        s_source_amount <= amt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_q.push_back(typed ? res : convert_amount(src, dst, amt));
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    function automatic logic [63:0] rand_amount();
        logic [63:0] v;
        int          k;
        v = {$urandom, $urandom};
        k = $urandom_range(9);
        case (k)
            0, 1, 2: return $urandom_range(1000000);
            3:       return v;
            4:       return {1'b0, v[62:0]};
            5:       return v >> $urandom_range(63);
            6:       return MAX_POS - $urandom_range(3);
            7:       return ($urandom_range(1) != 0) ? NONE_AMT : 64'd0;
            default: return {32'd0, v[31:0]};
        endcase
    endfunction

    function automatic dir_row_t mk_row(logic [1:0] src, logic [1:0] dst, logic [63:0] amt,
                                        int setting, bit typed, logic [63:0] e_amt,
                                        logic [1:0] e_st, logic e_ovf);
        dir_row_t d;
        d.src = src; d.dst = dst; d.amt = amt; d.setting = setting; d.typed = typed;
        d.res = '{amount: e_amt, status: e_st, ovf: e_ovf};
        return d;
    endfunction

    // receiver: random stalls, plus one long hold-off once traffic is flowing
    initial begin
        int n;
        hold_done = 1'b0;
        forever begin
            if (!hold_done && results_seen >= 400) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            n = gap_len();
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(12, 1)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        conv_res_t e;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result amount=%h status=%0d ovf=%0b",
                         $time, m_target_amount, m_status, m_overflowed);
                fail_count++;
            end else begin
                e = pending_q.pop_front();
                if (e.amount !== m_target_amount) begin
                    $display("%0t: target_amount expected %h actual %h",
                             $time, e.amount, m_target_amount);
                    fail_count++;
                end
                if (e.status !== m_status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, m_status);
                    fail_count++;
                end
                if (e.ovf !== m_overflowed) begin
                    $display("%0t: overflowed expected %0b actual %0b",
                             $time, e.ovf, m_overflowed);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int set_b[8];
        int set_r[8];
        int cur_set;
        logic [1:0] su;
        logic [1:0] tu;
        conv_res_t  none_res;
        set_b = '{0, 4, 1024, 1, 6, 0, 1024, 1};
        set_r = '{0, 48000, 1048575, 1, 0, 44100, 1, 1048575};
        none_res = '{amount: 64'd0, status: ST_OK, ovf: 1'b0};
        fail_count = 0;
        results_seen = 0;
        bytes_per_frame = '0;
        sample_rate = '0;
        aresetn         <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        s_valid         <= 1'b0;
        s_source_unit   <= '0;
        s_target_unit   <= '0;
        s_source_amount <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // setting 0 is the reset state: both registers zero
        dir_rows.push_back(mk_row(UNIT_BYTES, UNIT_BYTES, 64'd12345, 0, 1, 64'd12345, ST_OK, 0));
        dir_rows.push_back(mk_row(UNIT_OTHER, UNIT_OTHER, MAX_POS, 0, 1, MAX_POS, ST_OK, 0));
        dir_rows.push_back(mk_row(UNIT_FRAMES, UNIT_NS, 64'd0, 0, 1, 64'd0, ST_OK, 0));
        dir_rows.push_back(mk_row(UNIT_NS, UNIT_BYTES, NONE_AMT, 0, 1, NONE_AMT, ST_OK, 0));
        dir_rows.push_back(mk_row(UNIT_BYTES, UNIT_FRAMES, 64'd100, 0, 1, 64'd0, ST_NO_META, 0));
        dir_rows.push_back(mk_row(UNIT_OTHER, UNIT_NS, 64'd7, 0, 1, 64'd0, ST_NO_META, 0));
        // stereo 16-bit at 48 kHz
        dir_rows.push_back(mk_row(UNIT_OTHER, UNIT_BYTES, 64'd7, 1, 1, 64'd0,
                                  ST_UNSUPPORTED, 0));
        dir_rows.push_back(mk_row(UNIT_FRAMES, UNIT_OTHER, 64'd9, 1, 1, 64'd0,
                                  ST_UNSUPPORTED, 0));
        dir_rows.push_back(mk_row(UNIT_FRAMES, UNIT_BYTES, MAX_POS, 1, 1, MAX_POS, ST_OK, 1));
        dir_rows.push_back(mk_row(UNIT_BYTES, UNIT_FRAMES, 64'd192003, 1, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(UNIT_BYTES, UNIT_NS, 64'd192000, 1, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(UNIT_FRAMES, UNIT_NS, 64'd47999, 1, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(UNIT_NS, UNIT_BYTES, 64'd999999999, 1, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(UNIT_NS, UNIT_FRAMES, MAX_POS, 1, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(UNIT_BYTES, UNIT_NS, 64'hFFFF_FFFF_FFFF_FFFE, 1, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(UNIT_NS, UNIT_FRAMES, 64'h8000_0000_0000_0000, 1, 0, 0, 0, 0));
        // widest settings
        dir_rows.push_back(mk_row(UNIT_NS, UNIT_BYTES, MAX_POS, 2, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(UNIT_BYTES, UNIT_NS, MAX_POS, 2, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(UNIT_FRAMES, UNIT_NS, 64'd1, 2, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(UNIT_BYTES, UNIT_FRAMES, 64'd1023, 2, 0, 0, 0, 0));
        // narrowest nonzero settings
        dir_rows.push_back(mk_row(UNIT_FRAMES, UNIT_NS, MAX_POS, 3, 1, MAX_POS, ST_OK, 1));
        dir_rows.push_back(mk_row(UNIT_NS, UNIT_FRAMES, 64'd999999999, 3, 1, 64'd0, ST_OK, 0));
        dir_rows.push_back(mk_row(UNIT_NS, UNIT_BYTES, 64'd1000000000, 3, 1, 64'd1, ST_OK, 0));

        cur_set = 0;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].setting != cur_set) begin
                cur_set = dir_rows[i].setting;
                apply_setting(set_b[cur_set], set_r[cur_set]);
            end
            send_query(dir_rows[i].src, dir_rows[i].dst, dir_rows[i].amt,
                       dir_rows[i].typed, dir_rows[i].res);
        end

        for (int ph = 0; ph < 8; ph++) begin
            // pause the sender until the pipe is empty, then retune
            if (ph == 7) apply_setting($urandom_range(1024), $urandom_range(1048575));
            else apply_setting(set_b[(ph + 1) % 8], set_r[(ph + 1) % 8]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 85) begin
                    su = $urandom_range(2);
                    tu = (su + $urandom_range(2, 1)) % 3;
                end else begin
                    su = $urandom_range(3);
                    tu = $urandom_range(3);
                end
                send_query(su, tu, rand_amount(), 1'b0, none_res);
            end
        end

        drain_results();
        repeat (80) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
